// ===== src/ffa_pkg.sv =====
`default_nettype none
package ffa_pkg;

    localparam int unsigned ADDR_W  = 21;
    localparam int unsigned OFF_W   = 20;
    localparam int unsigned REQ_W   = 21;
    localparam int unsigned PAGES_W = 9;
    localparam int unsigned PAGE_LIMIT = 256;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_UNINIT = 2'd1,
        ST_NOMEM  = 2'd2,
        ST_BADPTR = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INIT,
        OP_SPLIT,
        OP_MERGE,
        OP_SETFREE
    } op_t;

    typedef struct packed {
        logic              valid;
        logic              free;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] bytes;
    } chunk_t;

    // broadcast to every cell; the target index travels beside it
    typedef struct packed {
        op_t               op;
        logic              split;
        logic              func;
        logic [REQ_W-1:0]  req;
        logic [OFF_W-1:0]  off;
        logic              init_valid;
        logic [ADDR_W-1:0] init_bytes;
    } cmd_t;

endpackage
`default_nettype wire

// ===== src/ffa_cell.sv =====
`default_nettype none
module ffa_cell #(
    parameter int unsigned IDX          = 0,
    parameter int unsigned IDX_W        = 6,
    parameter int unsigned HEADER_BYTES = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire ffa_pkg::cmd_t    cmd,
    input  wire logic [IDX_W-1:0] idx,
    input  wire ffa_pkg::chunk_t  prev_chunk,
    input  wire ffa_pkg::chunk_t  next_chunk,
    output ffa_pkg::chunk_t       chunk,
    output logic                  hit,
    output logic                  roomy
);

    localparam int unsigned AW = ffa_pkg::ADDR_W;
    localparam logic [IDX_W-1:0] ME = IDX_W'(IDX);
    localparam logic [IDX_W-1:0] PREV = IDX_W'((IDX > 0) ? IDX - 1 : 0);
    localparam logic HAS_PREV = (IDX > 0);
    localparam logic [AW:0] HDR = (AW+1)'(HEADER_BYTES);

    ffa_pkg::chunk_t chunk_reg, chunk_next;
    logic hit_reg, hit_next, roomy_reg, roomy_next;
    logic [AW:0] user_off, need;

    always_comb begin
        user_off   = {1'b0, chunk_reg.start} + HDR;
        need       = {1'b0, cmd.req} + HDR;
        hit_next   = chunk_reg.valid && (cmd.func
                     ? (user_off == {2'b0, cmd.off})
                     : (chunk_reg.free && chunk_reg.bytes >= cmd.req));
        roomy_next = ({1'b0, chunk_reg.bytes} >= need);
    end

    always_comb begin
        chunk_next = chunk_reg;
        unique case (cmd.op)
            ffa_pkg::OP_INIT: begin
                chunk_next = '0;
                if (IDX == 0) begin
                    chunk_next.valid = cmd.init_valid;
                    chunk_next.free  = cmd.init_valid;
                    chunk_next.bytes = cmd.init_valid ? cmd.init_bytes : '0;
                end
            end
            ffa_pkg::OP_SPLIT: begin
                if (ME == idx) begin
                    chunk_next.free = 1'b0;
                    if (cmd.split) chunk_next.bytes = cmd.req;
                end else if (cmd.split && HAS_PREV && PREV == idx) begin
                    chunk_next.valid = 1'b1;
                    chunk_next.free  = 1'b1;
                    chunk_next.start = AW'({1'b0, prev_chunk.start} + need);
                    chunk_next.bytes = AW'({1'b0, prev_chunk.bytes} - need);
                end else if (cmd.split && HAS_PREV && PREV > idx) begin
                    chunk_next = prev_chunk;
                end
            end
            ffa_pkg::OP_MERGE: begin
                if (ME == idx) begin
                    chunk_next.free  = 1'b1;
                    chunk_next.bytes = AW'({1'b0, chunk_reg.bytes}
                                           + {1'b0, next_chunk.bytes} + HDR);
                end else if (ME > idx) begin
                    chunk_next = next_chunk;
                end
            end
            ffa_pkg::OP_SETFREE: begin
                if (ME == idx) chunk_next.free = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_reg <= '0;
        end else begin
            chunk_reg <= chunk_next;
        end
        hit_reg   <= hit_next;
        roomy_reg <= roomy_next;
    end

    assign chunk = chunk_reg;
    assign hit   = hit_reg;
    assign roomy = roomy_reg;

endmodule
`default_nettype wire

// ===== src/first_fit_arena_allocator.sv =====
// First-fit arena allocator.
// Config: APB write of arena_pages (offsets 0 to 3) rebuilds the table as one free
// chunk covering the arena less one header; 0 leaves the block uninitialized.
// Pages above 256 saturate. pready is always high; prdata returns the count.
// Input channel s_*: func 0 allocates s_request_bytes, func 1 frees the
// chunk whose user offset is s_free_offset. One request is in flight at a
// time; s_ready is high only while idle.
// Result channel m_*: status and alloc_offset (user offset, 0 on failure or
// for a free). The result is held in an output register until the transfer.
// An allocate passes flag evaluation in the cells, priority select and
// split/shift before m_valid; a free passes flag evaluation, priority select
// and two merge steps; an uninitialized block answers directly. The table
// is a chain of cells shifting to neighbors, one split or merge at a time.
// Reset clears the table (uninitialized) and drops any pending result.
// A stalled receiver holds the block: no new request is taken meanwhile.
`default_nettype none
module first_fit_arena_allocator #(
    parameter int unsigned MAX_CHUNKS   = 64,
    parameter int unsigned HEADER_BYTES = 32,
    parameter int unsigned PAGE_BYTES   = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_func,
    input  wire logic [20:0] s_request_bytes,
    input  wire logic [19:0] s_free_offset,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [19:0]      m_alloc_offset
);

    localparam int unsigned IDX_W = $clog2(MAX_CHUNKS);
    localparam int unsigned CNT_W = $clog2(MAX_CHUNKS + 1);
    localparam int unsigned AW    = ffa_pkg::ADDR_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHUNKS);
    localparam logic [AW:0] HDR = (AW+1)'(HEADER_BYTES);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EVAL = 6'b000010,
        S_SEL  = 6'b000100,
        S_ACT  = 6'b001000,
        S_PREV = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [ffa_pkg::PAGES_W-1:0] pages_reg, pages_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic func_reg, func_next;
    logic [ffa_pkg::REQ_W-1:0] req_reg, req_next;
    logic [ffa_pkg::OFF_W-1:0] off_reg, off_next;
    ffa_pkg::status_t status_reg, status_next;
    logic [ffa_pkg::OFF_W-1:0] result_reg, result_next;

    ffa_pkg::cmd_t cmd;
    logic [IDX_W-1:0] cmd_idx;
    ffa_pkg::chunk_t chunks [MAX_CHUNKS];
    logic [MAX_CHUNKS-1:0] hits, roomys, next_free, prev_free;
    logic [IDX_W-1:0] first_idx;
    logic found;
    logic [AW-1:0] sel_start;
    logic cfg_write;
    logic [ffa_pkg::PAGES_W-1:0] wr_pages;
    logic [31:0] arena_bytes;

    genvar g;
    generate
        for (g = 0; g < MAX_CHUNKS; g++) begin : g_cell
            ffa_pkg::chunk_t prev_c, next_c;
            if (g == 0) begin : g_first
                assign prev_c = '0;
            end else begin : g_mid
                assign prev_c = chunks[g-1];
            end
            if (g == MAX_CHUNKS - 1) begin : g_last
                assign next_c = '0;
            end else begin : g_inner
                assign next_c = chunks[g+1];
            end
            ffa_cell #(
                .IDX(g), .IDX_W(IDX_W), .HEADER_BYTES(HEADER_BYTES)
            ) u_cell (
                .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .idx(cmd_idx),
                .prev_chunk(prev_c), .next_chunk(next_c),
                .chunk(chunks[g]), .hit(hits[g]), .roomy(roomys[g])
            );
            assign next_free[g] = next_c.valid && next_c.free;
            assign prev_free[g] = prev_c.valid && prev_c.free;
        end
    endgenerate

    always_comb begin
        first_idx = '0;
        found     = 1'b0;
        for (int j = MAX_CHUNKS - 1; j >= 0; j--) begin
            if (hits[j]) begin
                first_idx = IDX_W'(j);
                found     = 1'b1;
            end
        end
        sel_start = '0;
        for (int j = 0; j < MAX_CHUNKS; j++) begin
            if (idx_reg == IDX_W'(j)) sel_start = sel_start | chunks[j].start;
        end
    end

    assign cfg_write = psel && penable && pwrite && !paddr[2];
    assign wr_pages  = (pwdata[8:0] > 9'(ffa_pkg::PAGE_LIMIT))
                       ? 9'(ffa_pkg::PAGE_LIMIT) : pwdata[8:0];
    assign arena_bytes = 32'(wr_pages) * 32'(PAGE_BYTES) - 32'(HEADER_BYTES);

    always_comb begin
        state_next  = state_reg;
        pages_next  = pages_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        func_next   = func_reg;
        req_next    = req_reg;
        off_next    = off_reg;
        status_next = status_reg;
        result_next = result_reg;
        cmd            = '0;
        cmd.op         = ffa_pkg::OP_NONE;
        cmd.func       = func_reg;
        cmd.req        = req_reg;
        cmd.off        = off_reg;
        cmd.init_bytes = arena_bytes[AW-1:0];
        cmd.init_valid = (wr_pages != '0);
        cmd_idx        = idx_reg;

        if (cfg_write) begin
            cmd.op     = ffa_pkg::OP_INIT;
            pages_next = wr_pages;
            count_next = (wr_pages != '0) ? CNT_W'(1) : '0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    func_next   = s_func;
                    req_next    = s_request_bytes;
                    off_next    = s_free_offset;
                    result_next = '0;
                    if (count_reg == '0) begin
                        status_next = ffa_pkg::ST_UNINIT;
                        state_next  = S_OUT;
                    end else begin
                        state_next = S_EVAL;
                    end
                end
            end
            S_EVAL: state_next = S_SEL;
            S_SEL: begin
                idx_next = first_idx;
                if (found) begin
                    state_next = S_ACT;
                end else begin
                    status_next = func_reg ? ffa_pkg::ST_BADPTR : ffa_pkg::ST_NOMEM;
                    state_next  = S_OUT;
                end
            end
            S_ACT: begin
                status_next = ffa_pkg::ST_OK;
                if (!func_reg) begin
                    cmd.op    = ffa_pkg::OP_SPLIT;
                    cmd.split = roomys[idx_reg] && (count_reg < CNT_MAX);
                    if (cmd.split) count_next = count_reg + CNT_W'(1);
                    result_next = ffa_pkg::OFF_W'({1'b0, sel_start} + HDR);
                    state_next  = S_OUT;
                end else begin
                    if (next_free[idx_reg]) begin
                        cmd.op     = ffa_pkg::OP_MERGE;
                        count_next = count_reg - CNT_W'(1);
                    end else begin
                        cmd.op = ffa_pkg::OP_SETFREE;
                    end
                    state_next = S_PREV;
                end
            end
            S_PREV: begin
                // the chunk before is untouched by the first merge
                if (prev_free[idx_reg]) begin
                    cmd.op     = ffa_pkg::OP_MERGE;
                    cmd_idx    = idx_reg - IDX_W'(1);
                    count_next = count_reg - CNT_W'(1);
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pages_reg <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            pages_reg <= pages_next;
            count_reg <= count_next;
        end
        idx_reg    <= idx_next;
        func_reg   <= func_next;
        req_reg    <= req_next;
        off_reg    <= off_next;
        status_reg <= status_next;
        result_reg <= result_next;
    end

    assign prdata         = 32'(pages_reg);
    assign pready         = 1'b1;
    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = (state_reg == S_OUT);
    assign m_status       = status_reg;
    assign m_alloc_offset = result_reg;

endmodule
`default_nettype wire

// ===== src/ffa_checker.sv =====
`default_nettype none
module ffa_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_status,
    input wire logic [19:0] m_alloc_offset
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_alloc_offset))
        else $error("result changed while stalled");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ffa_pkg::ST_OK |-> m_alloc_offset == '0)
        else $error("failed request carries an offset");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while busy");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input open while result pending");

endmodule

bind first_fit_arena_allocator ffa_checker u_ffa_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_alloc_offset(m_alloc_offset)
);
`default_nettype wire
